[rtl/smpd_pkg.sv]
package smpd_pkg;

  localparam int unsigned PosW     = 16;
  localparam int unsigned DutyW    = 10;
  localparam int unsigned CfgIdxW  = 2;
  // Phase table length; a power of two.
  localparam int unsigned TableEntries = 128;
  localparam int unsigned IdxW     = $clog2(TableEntries);
  localparam int unsigned SampleW  = 7;
  localparam int unsigned NumPhase = 4;

  localparam logic [DutyW-1:0] DutyFloor = 10'd50;

  // Quarter-turn offsets for phases a, b, c, d.
  localparam logic [IdxW-1:0] OffsA = IdxW'(0);
  localparam logic [IdxW-1:0] OffsB = IdxW'(2 * TableEntries / 4);
  localparam logic [IdxW-1:0] OffsC = IdxW'(1 * TableEntries / 4);
  localparam logic [IdxW-1:0] OffsD = IdxW'(3 * TableEntries / 4);

  typedef enum logic [CfgIdxW-1:0] {
    RegMinPos  = 2'd0,
    RegMaxPos  = 2'd1,
    RegLpDelay = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            low_power;
  } step_t;

  typedef logic [NumPhase-1:0][DutyW-1:0] duty_arr_t;

  // First half of the sine; second half of each table sits at the floor.
  localparam logic [DutyW-1:0] FullTab [64] = '{
    10'd50,  10'd76,  10'd102, 10'd128, 10'd153, 10'd179, 10'd204, 10'd229,
    10'd253, 10'd277, 10'd300, 10'd322, 10'd344, 10'd366, 10'd386, 10'd406,
    10'd425, 10'd443, 10'd460, 10'd476, 10'd491, 10'd505, 10'd517, 10'd529,
    10'd540, 10'd549, 10'd557, 10'd564, 10'd570, 10'd574, 10'd577, 10'd579,
    10'd580, 10'd579, 10'd577, 10'd574, 10'd570, 10'd564, 10'd557, 10'd549,
    10'd540, 10'd529, 10'd517, 10'd505, 10'd491, 10'd476, 10'd460, 10'd443,
    10'd425, 10'd406, 10'd386, 10'd366, 10'd344, 10'd322, 10'd300, 10'd277,
    10'd253, 10'd229, 10'd204, 10'd179, 10'd153, 10'd128, 10'd102, 10'd76
  };

  localparam logic [DutyW-1:0] LowTab [64] = '{
    10'd50,  10'd65,  10'd79,  10'd94,  10'd109, 10'd123, 10'd137, 10'd151,
    10'd165, 10'd178, 10'd191, 10'd204, 10'd217, 10'd229, 10'd240, 10'd251,
    10'd262, 10'd272, 10'd282, 10'd291, 10'd299, 10'd307, 10'd315, 10'd321,
    10'd327, 10'd332, 10'd337, 10'd341, 10'd344, 10'd347, 10'd349, 10'd350,
    10'd350, 10'd350, 10'd349, 10'd347, 10'd344, 10'd341, 10'd337, 10'd332,
    10'd327, 10'd321, 10'd315, 10'd307, 10'd299, 10'd291, 10'd282, 10'd272,
    10'd262, 10'd251, 10'd240, 10'd229, 10'd217, 10'd204, 10'd191, 10'd178,
    10'd165, 10'd151, 10'd137, 10'd123, 10'd109, 10'd94,  10'd79,  10'd65
  };

  // Phase index to sample number: idx * 128 / TableEntries.
  function automatic logic [SampleW-1:0] to_sample(logic [IdxW-1:0] idx);
    logic [IdxW+SampleW-1:0] w;
    w = {idx, {SampleW{1'b0}}};
    return SampleW'(w >> IdxW);
  endfunction

  function automatic logic [DutyW-1:0] duty_lookup(logic [SampleW-1:0] s, logic lowp);
    logic [DutyW-1:0] d;
    if (s[SampleW-1]) begin
      d = DutyFloor;
    end else if (lowp) begin
      d = LowTab[s[SampleW-2:0]];
    end else begin
      d = FullTab[s[SampleW-2:0]];
    end
    return d;
  endfunction

endpackage

[rtl/smpd_step.sv]
module smpd_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [smpd_pkg::PosW-1:0] target_i,
  input  logic [smpd_pkg::PosW-1:0] min_pos_i,
  input  logic [smpd_pkg::PosW-1:0] max_pos_i,
  input  logic [smpd_pkg::PosW-1:0] lp_delay_i,
  output smpd_pkg::step_t           res_o
);
  import smpd_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] stop_q, stop_d;
  logic [PosW-1:0] tgt_hi, tgt;
  logic [PosW-1:0] stop_inc;
  logic            lowp;

  always_comb begin
    tgt_hi = (target_i > max_pos_i) ? max_pos_i : target_i;
    tgt    = (tgt_hi < min_pos_i) ? min_pos_i : tgt_hi;
    // saturating count while parked
    stop_inc = (&stop_q) ? stop_q : stop_q + 1'b1;

    pos_d  = pos_q;
    stop_d = stop_inc;
    if (pos_q > tgt) begin
      pos_d  = pos_q - 1'b1;
      stop_d = '0;
    end else if (pos_q < tgt) begin
      pos_d  = pos_q + 1'b1;
      stop_d = '0;
    end

    lowp = 1'b0;
    if (stop_d >= lp_delay_i) begin
      stop_d = lp_delay_i;
      lowp   = 1'b1;
    end

    res_o.position  = pos_d;
    res_o.low_power = lowp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      stop_q <= '0;
    end else if (en_i) begin
      pos_q  <= pos_d;
      stop_q <= stop_d;
    end
  end

endmodule

[rtl/smpd_phase.sv]
module smpd_phase (
  input  logic [smpd_pkg::PosW-1:0] position_i,
  input  logic                      low_power_i,
  output smpd_pkg::duty_arr_t       duty_o
);
  import smpd_pkg::*;

  logic [IdxW-1:0] base;
  logic [IdxW-1:0] idx [NumPhase];

  // mod TableEntries is just the low bits
  assign base   = position_i[IdxW-1:0];
  assign idx[0] = base + OffsA;
  assign idx[1] = base + OffsB;
  assign idx[2] = base + OffsC;
  assign idx[3] = base + OffsD;

  always_comb begin
    for (int p = 0; p < NumPhase; p++) begin
      duty_o[p] = duty_lookup(to_sample(idx[p]), low_power_i);
    end
  end

endmodule

[rtl/stepper_microstep_position_driver.sv]
// Channel   Dir  Handshake                 Payload
// target    in   in_valid_i / in_ready_o    target_position_i
// result    out  out_valid_o / out_ready_i  position_o, duty_phase_[a-d]_o, low_power_o
// config    in   cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// One item per clock sustained while the output is not stalled; results are registered.
// The item sits in an input register; clamp, step and table lookups run in one
// pass between it and the result register, where motor state also updates.
// Output stall: input register holds, so a third item is refused until space frees.
// Reset: position and stopped count zero, limits 0/65520, low-power delay 1000.
module stepper_microstep_position_driver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config
  input  logic                         cfg_we_i,
  input  logic [smpd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [smpd_pkg::PosW-1:0]    cfg_data_i,
  // target channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [smpd_pkg::PosW-1:0]    target_position_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [smpd_pkg::PosW-1:0]    position_o,
  output logic [smpd_pkg::DutyW-1:0]   duty_phase_a_o,
  output logic [smpd_pkg::DutyW-1:0]   duty_phase_b_o,
  output logic [smpd_pkg::DutyW-1:0]   duty_phase_c_o,
  output logic [smpd_pkg::DutyW-1:0]   duty_phase_d_o,
  output logic                         low_power_o
);
  import smpd_pkg::*;

  // configuration registers
  logic [PosW-1:0] min_pos_q, max_pos_q, lp_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pos_q  <= 16'd0;
      max_pos_q  <= 16'd65520;
      lp_delay_q <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMinPos:  min_pos_q  <= cfg_data_i;
        RegMaxPos:  max_pos_q  <= cfg_data_i;
        RegLpDelay: lp_delay_q <= cfg_data_i;
        default: ;  // unmapped index, ignore
      endcase
    end
  end

  // input register
  logic            s1_valid_q;
  logic [PosW-1:0] s1_tgt_q;
  logic            s1_adv;
  logic            in_fire;

  // result register
  logic            out_valid_q;
  logic [PosW-1:0] out_pos_q;
  duty_arr_t       out_duty_q;
  logic            out_lowp_q;

  step_t           step_res;
  duty_arr_t       duty;

  // stage 1 moves on whenever the result register is empty or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_tgt_q <= target_position_i;
    end
  end

  // motor state is committed only when the item moves to the result register
  smpd_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (s1_adv),
    .target_i   (s1_tgt_q),
    .min_pos_i  (min_pos_q),
    .max_pos_i  (max_pos_q),
    .lp_delay_i (lp_delay_q),
    .res_o      (step_res)
  );

  smpd_phase u_phase (
    .position_i  (step_res.position),
    .low_power_i (step_res.low_power),
    .duty_o      (duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pos_q  <= step_res.position;
      out_duty_q <= duty;
      out_lowp_q <= step_res.low_power;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = out_pos_q;
  assign duty_phase_a_o = out_duty_q[0];
  assign duty_phase_b_o = out_duty_q[1];
  assign duty_phase_c_o = out_duty_q[2];
  assign duty_phase_d_o = out_duty_q[3];
  assign low_power_o    = out_lowp_q;

  // refusing input only when both stages are full and the output is stalled
  a_ready_low_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input refused with room available");

  // low-power table never exceeds its peak
  a_lowp_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_lowp_q) |-> (out_duty_q[0] <= 10'd350 && out_duty_q[1] <= 10'd350
      && out_duty_q[2] <= 10'd350 && out_duty_q[3] <= 10'd350))
    else $error("low-power duty above table peak");

  // phases a and b are half a turn apart, so one of them is on the floor
  a_ab_opposed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_duty_q[0] == DutyFloor || out_duty_q[1] == DutyFloor))
    else $error("phases a and b both energised");

  // each new result moves at most one microstep
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && s1_adv) |=> (position_o == $past(out_pos_q)
      || position_o == $past(out_pos_q) + 16'd1 || position_o == $past(out_pos_q) - 16'd1))
    else $error("position jumped by more than one step");

endmodule
